// ----- rtl/pol_pkg.sv -----
`default_nettype none

package pol_pkg;

   // term count and register file
   localparam int NUM_COEF  = 8;
   localparam int MAX_TERMS = 8;
   localparam int IDX_W     = $clog2(NUM_COEF);

   // field widths
   localparam int X_W    = 16;   // limits, Q2.14
   localparam int COEF_W = 32;   // coefficients, Q8.24
   localparam int OUT_W  = 48;   // results, Q24.24

   // power of x, 32 fraction bits
   localparam int P_W      = 42;
   localparam int POW_SH   = 14;
   localparam int PPROD_W  = P_W + X_W;

   // rounded product unit: a * p / 2^32, half up
   localparam int FRAC_Q = 32;
   localparam int MA_W   = 34;
   localparam int MP_W   = P_W + 1;
   localparam int LO_W   = 16;
   localparam int HI_W   = MP_W - LO_W;
   localparam int PPH_W  = MA_W + HI_W;
   localparam int PPL_W  = MA_W + LO_W + 1;
   localparam int T_W    = PPH_W + 1;
   localparam int Q_W    = 44;

   // sums, wide enough that the clamp is a real compare
   localparam int ACC_W = Q_W + 6;

   // stages in one cell
   localparam int CELL_STAGES = 6;

   typedef logic [IDX_W-1:0]          pol_idx_type;
   typedef logic signed [P_W-1:0]     pol_pow_type;
   typedef logic signed [PPROD_W-1:0] pol_pprod_type;
   typedef logic signed [MA_W-1:0]    pol_ma_type;
   typedef logic signed [MP_W-1:0]    pol_mp_type;
   typedef logic signed [PPL_W-1:0]   pol_ppl_type;
   typedef logic signed [T_W-1:0]     pol_t_type;
   typedef logic signed [Q_W-1:0]     pol_q_type;
   typedef logic signed [ACC_W-1:0]   pol_acc_type;

   localparam pol_pow_type   P_ONE    = pol_pow_type'(64'd1 << FRAC_Q);
   localparam pol_pprod_type POW_HALF = pol_pprod_type'(64'd1 << (POW_SH - 1));
   localparam pol_ppl_type   PP_HALF  = pol_ppl_type'(64'd1 << (FRAC_Q - 1));

   // clamp limits of a Q24.24 result
   localparam pol_acc_type SAT_HI = {{(ACC_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
   localparam pol_acc_type SAT_LO = {{(ACC_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

   // data handed from cell to cell
   typedef struct packed {
      logic                    valid;
      logic signed [X_W-1:0]   xh;
      logic signed [X_W-1:0]   xl;
      pol_pow_type             ph;
      pol_pow_type             pl;
      pol_acc_type             acc_val;
      pol_acc_type             acc_area;
   } pol_bus_type;

   // round(2^32 / (i + 1)) for term i
   function automatic logic [FRAC_Q:0] recip(input pol_idx_type idx);
      logic [FRAC_Q:0] r;
      unique case (idx)
         3'd0: r = 33'd4294967296;
         3'd1: r = 33'd2147483648;
         3'd2: r = 33'd1431655765;
         3'd3: r = 33'd1073741824;
         3'd4: r = 33'd858993459;
         3'd5: r = 33'd715827883;
         3'd6: r = 33'd613566757;
         3'd7: r = 33'd536870912;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/polynomial_eval_and_integral.sv -----
// Polynomial value and definite integral, one item per clock while the chain moves.
// Coefficients coef_0..coef_7 (signed Q8.24) are written through the csr port:
// csr_we with csr_index and csr_wdata writes one register in that cycle. Write
// them only while no item is in flight. Reset clears all coefficients to zero.
// An item on the req channel (valid/ready) carries x_low and x_high, signed
// Q2.14. The rsp channel returns the value at x_high, the integral from x_low
// to x_high (both signed Q24.24, clamped) and an overflow flag.
// Each term is one cell of six stages; the cells form a chain that carries the
// powers of both limits and the two running sums. A new item can be accepted
// every cycle while the chain moves, as the pipeline holds one item per stage.
// When the receiver stalls, the result holds in the output register and the
// chain keeps moving while its last stage is empty; it stops, with req_ready
// low, only when a finished item is waiting behind the held result.
// Reset empties the pipeline; no result is lost or repeated across a stall.
`default_nettype none

module polynomial_eval_and_integral (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [pol_pkg::X_W-1:0]        req_x_low,
   input  wire logic signed [pol_pkg::X_W-1:0]        req_x_high,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [pol_pkg::OUT_W-1:0]           rsp_value_at_high,
   output logic signed [pol_pkg::OUT_W-1:0]           rsp_area,
   output logic                                       rsp_overflow,
   input  wire logic                                  csr_we,
   input  wire logic [pol_pkg::IDX_W-1:0]             csr_index,
   input  wire logic signed [pol_pkg::COEF_W-1:0]     csr_wdata
);

   logic signed [pol_pkg::COEF_W-1:0] coef_ff [pol_pkg::NUM_COEF];
   pol_pkg::pol_bus_type head;
   pol_pkg::pol_bus_type bus [pol_pkg::MAX_TERMS];
   pol_pkg::pol_bus_type tail;
   logic                 adv;
   logic                 val_hi, val_lo, area_hi, area_lo;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [pol_pkg::OUT_W-1:0] value_ff, value_in, area_ff, area_in;
   logic                 ovf_ff, ovf_in;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < pol_pkg::NUM_COEF; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // chain moves unless a finished item waits behind a held result
   assign tail      = bus[pol_pkg::MAX_TERMS-1];
   assign adv       = !(tail.valid && rsp_valid_ff && !rsp_ready);
   assign req_ready = adv;

   // item entering the chain: x^0 for both limits, empty sums
   always_comb begin
      head.valid    = req_valid;
      head.xh       = req_x_high;
      head.xl       = req_x_low;
      head.ph       = pol_pkg::P_ONE;
      head.pl       = pol_pkg::P_ONE;
      head.acc_val  = '0;
      head.acc_area = '0;
   end

   // one cell per term
   for (genvar i = 0; i < pol_pkg::MAX_TERMS; i++) begin : g_cell
      if (i == 0) begin : g_first
         pol_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .en      (adv),
            .coef    (coef_ff[i]),
            .recip   (pol_pkg::recip(pol_pkg::pol_idx_type'(i))),
            .bus_in  (head),
            .bus_out (bus[i])
         );
      end else begin : g_next
         pol_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .en      (adv),
            .coef    (coef_ff[i]),
            .recip   (pol_pkg::recip(pol_pkg::pol_idx_type'(i))),
            .bus_in  (bus[i-1]),
            .bus_out (bus[i])
         );
      end
   end

   // clamp both sums to Q24.24
   always_comb begin
      val_hi  = tail.acc_val > pol_pkg::SAT_HI;
      val_lo  = tail.acc_val < pol_pkg::SAT_LO;
      area_hi = tail.acc_area > pol_pkg::SAT_HI;
      area_lo = tail.acc_area < pol_pkg::SAT_LO;
      if (val_hi) begin
         value_in = pol_pkg::OUT_MAX;
      end else if (val_lo) begin
         value_in = pol_pkg::OUT_MIN;
      end else begin
         value_in = tail.acc_val[pol_pkg::OUT_W-1:0];
      end
      if (area_hi) begin
         area_in = pol_pkg::OUT_MAX;
      end else if (area_lo) begin
         area_in = pol_pkg::OUT_MIN;
      end else begin
         area_in = tail.acc_area[pol_pkg::OUT_W-1:0];
      end
      ovf_in = val_hi || val_lo || area_hi || area_lo;
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (adv && tail.valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (adv && tail.valid) begin
         value_ff <= value_in;
         area_ff  <= area_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value_at_high = value_ff;
   assign rsp_area          = area_ff;
   assign rsp_overflow      = ovf_ff;

endmodule

`default_nettype wire

// ----- rtl/pol_qmul.sv -----
`default_nettype none

module pol_qmul (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire pol_pkg::pol_ma_type mul_a,
   input  wire pol_pkg::pol_mp_type mul_p,
   output pol_pkg::pol_q_type       product
);

   logic signed [pol_pkg::HI_W-1:0]  p_hi;
   logic signed [pol_pkg::LO_W:0]    p_lo;
   logic signed [pol_pkg::PPH_W-1:0] hi_in, hi_ff;
   pol_pkg::pol_ppl_type             lo_in, lo_ff;
   pol_pkg::pol_ppl_type             lo_rnd;
   pol_pkg::pol_t_type               t_sum;
   pol_pkg::pol_q_type               prod_in, prod_ff;

   // split the wide operand into a signed high and an unsigned low part
   assign p_hi  = mul_p[pol_pkg::MP_W-1:pol_pkg::LO_W];
   assign p_lo  = $signed({1'b0, mul_p[pol_pkg::LO_W-1:0]});
   assign hi_in = mul_a * p_hi;
   assign lo_in = mul_a * p_lo;

   // recombine with rounding, then drop 32 fraction bits
   always_comb begin
      lo_rnd  = lo_ff + pol_pkg::PP_HALF;
      t_sum   = pol_pkg::pol_t_type'(hi_ff) + pol_pkg::pol_t_type'(lo_rnd >>> pol_pkg::LO_W);
      prod_in = t_sum[pol_pkg::FRAC_Q-pol_pkg::LO_W+pol_pkg::Q_W-1:
                      pol_pkg::FRAC_Q-pol_pkg::LO_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

`default_nettype wire

// ----- rtl/pol_cell.sv -----
`default_nettype none

module pol_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic signed [pol_pkg::COEF_W-1:0] coef,
   input  wire logic [pol_pkg::FRAC_Q:0]      recip,
   input  wire pol_pkg::pol_bus_type          bus_in,
   output pol_pkg::pol_bus_type               bus_out
);

   // stage where each term joins its sum
   localparam int VAL_STAGE  = 2;
   localparam int AREA_STAGE = 5;

   pol_pkg::pol_bus_type  s_ff [pol_pkg::CELL_STAGES];
   pol_pkg::pol_bus_type  s_in [pol_pkg::CELL_STAGES];
   pol_pkg::pol_pprod_type ph_prod, pl_prod, ph_rnd, pl_rnd;
   pol_pkg::pol_mp_type   diff;
   pol_pkg::pol_q_type    vterm, qterm, iterm;

   // next power of both limits
   always_comb begin
      ph_prod = bus_in.ph * bus_in.xh;
      pl_prod = bus_in.pl * bus_in.xl;
      ph_rnd  = ph_prod + pol_pkg::POW_HALF;
      pl_rnd  = pl_prod + pol_pkg::POW_HALF;
   end

   // difference of the next powers, one stage later
   assign diff = pol_pkg::pol_mp_type'(s_ff[0].ph) - pol_pkg::pol_mp_type'(s_ff[0].pl);

   // coefficient times current power of the upper limit
   pol_qmul u_qmul_val (
      .clock   (clock),
      .en      (en),
      .mul_a   (pol_pkg::pol_ma_type'(coef)),
      .mul_p   (pol_pkg::pol_mp_type'(bus_in.ph)),
      .product (vterm)
   );

   // coefficient times difference of the next powers
   pol_qmul u_qmul_diff (
      .clock   (clock),
      .en      (en),
      .mul_a   (pol_pkg::pol_ma_type'(coef)),
      .mul_p   (diff),
      .product (qterm)
   );

   // scale by the reciprocal of the new exponent
   pol_qmul u_qmul_recip (
      .clock   (clock),
      .en      (en),
      .mul_a   (pol_pkg::pol_ma_type'({1'b0, recip})),
      .mul_p   (pol_pkg::pol_mp_type'(qterm)),
      .product (iterm)
   );

   // stage contents
   always_comb begin
      for (int k = 0; k < pol_pkg::CELL_STAGES; k++) begin
         if (k == 0) begin
            s_in[k] = bus_in;
         end else begin
            s_in[k] = s_ff[k-1];
         end
      end
      s_in[0].ph = ph_rnd[pol_pkg::P_W+pol_pkg::POW_SH-1:pol_pkg::POW_SH];
      s_in[0].pl = pl_rnd[pol_pkg::P_W+pol_pkg::POW_SH-1:pol_pkg::POW_SH];
      s_in[VAL_STAGE].acc_val = s_ff[VAL_STAGE-1].acc_val + pol_pkg::pol_acc_type'(vterm);
      s_in[AREA_STAGE].acc_area = s_ff[AREA_STAGE-1].acc_area
                                + pol_pkg::pol_acc_type'(iterm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < pol_pkg::CELL_STAGES; k++) begin
            s_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < pol_pkg::CELL_STAGES; k++) begin
            s_ff[k] <= s_in[k];
         end
      end
   end

   assign bus_out = s_ff[pol_pkg::CELL_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/pol_checker.sv -----
`default_nettype none

module pol_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [pol_pkg::OUT_W-1:0]   rsp_value_at_high,
   input wire logic signed [pol_pkg::OUT_W-1:0]   rsp_area,
   input wire logic                               rsp_overflow
);

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_at_high)
                                 && $stable(rsp_area) && $stable(rsp_overflow))
      else $error("held result changed");

   // input stalls only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a waiting result");

   // overflow flag comes only with a clamped field
   a_ovf_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_value_at_high == pol_pkg::OUT_MAX || rsp_value_at_high == pol_pkg::OUT_MIN ||
         rsp_area == pol_pkg::OUT_MAX || rsp_area == pol_pkg::OUT_MIN)
      else $error("overflow without a clamped result");

endmodule

bind polynomial_eval_and_integral pol_checker u_pol_checker (.*);

`default_nettype wire

// ----- tb/tb_polynomial_eval_and_integral.sv -----
`default_nettype none

module tb_polynomial_eval_and_integral;

   localparam int LATENCY     = 48;
   localparam int NUM_COEF    = pol_pkg::NUM_COEF;
   localparam int MAX_TERMS   = pol_pkg::MAX_TERMS;
   localparam int NUM_PHASES  = 12;
   localparam int PHASE_ITEMS = 56;
   localparam int HOLD_CYCLES = 200;
   localparam int IDLE_PCT    = 19;

   typedef logic signed [pol_pkg::X_W-1:0]    lim_type;
   typedef logic signed [pol_pkg::COEF_W-1:0] coef_type;
   typedef logic signed [pol_pkg::OUT_W-1:0]  q48_type;
   typedef logic signed [127:0]               wide_type;
   typedef coef_type coef_set_type [NUM_COEF];

   typedef struct packed {
      q48_type value_at_high;
      q48_type area;
      logic    overflow;
   } va_result_type;

   // coefficient sets of the directed part
   typedef enum int {SET_ZERO, SET_UNITY, SET_ALL_MAX, SET_ALL_MIN, SET_X7} dir_set_type;

   // how a random phase picks its coefficients
   typedef enum int {CM_FULL, CM_EXTREME, CM_DEGREE, CM_SMALL} coef_mode_type;

   typedef struct {
      dir_set_type   set_id;
      lim_type       xl;
      lim_type       xh;
      bit            known;
      va_result_type fixed;
   } dir_row_type;

   localparam coef_type COEF_ONE = 32'sh0100_0000;
   localparam coef_type COEF_MAX = 32'sh7FFF_FFFF;
   localparam coef_type COEF_MIN = 32'sh8000_0000;
   localparam q48_type  VAL_ONE  = 48'sd16777216;
   localparam wide_type SUM_MAX  = (128'sd1 <<< 47) - 128'sd1;
   localparam wide_type SUM_MIN  = -(128'sd1 <<< 47);

   logic     clock      = 1'b0;
   logic     reset      = 1'b1;
   logic     req_valid  = 1'b0;
   logic     req_ready;
   lim_type  req_x_low  = '0;
   lim_type  req_x_high = '0;
   logic     rsp_valid;
   logic     rsp_ready  = 1'b0;
   q48_type  rsp_value_at_high;
   q48_type  rsp_area;
   logic     rsp_overflow;
   logic     csr_we     = 1'b0;
   pol_pkg::pol_idx_type csr_index = '0;
   coef_type csr_wdata  = '0;

   // typed-in expectation travels with the item
   logic          row_known  = 1'b0;
   va_result_type row_result = '0;

   coef_type      coef_copy [NUM_COEF];
   va_result_type value_area_q [$];
   dir_row_type   dir_tab [$];
   coef_set_type  dir_sets [5];
   int            err_count     = 0;
   int            result_no     = 0;
   bit            idle_on       = 1'b1;
   bit            pressure_go   = 1'b0;
   bit            pressure_done = 1'b0;
   int            hold_left     = 0;

   polynomial_eval_and_integral dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_x_low         (req_x_low),
      .req_x_high        (req_x_high),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value_at_high (rsp_value_at_high),
      .rsp_area          (rsp_area),
      .rsp_overflow      (rsp_overflow),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // clock, period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // rounded product a * p / 2^32, half up
   function automatic wide_type mul_q32(input wide_type a, input wide_type p);
      return (a * p + (128'sd1 <<< 31)) >>> 32;
   endfunction

   // value at the upper limit and integral over the interval
   function automatic va_result_type poly_value_and_area(input lim_type xl, input lim_type xh);
      wide_type      pow_h [NUM_COEF+1];
      wide_type      pow_l [NUM_COEF+1];
      wide_type      xh_w;
      wide_type      xl_w;
      wide_type      a_w;
      wide_type      recip;
      wide_type      val_sum;
      wide_type      area_sum;
      va_result_type r;
      xh_w = xh;
      xl_w = xl;
      // powers with 32 fraction bits
      pow_h[0] = 128'sd1 <<< 32;
      pow_l[0] = 128'sd1 <<< 32;
      pow_h[1] = xh_w <<< 18;
      pow_l[1] = xl_w <<< 18;
      for (int k = 1; k < NUM_COEF; k++) begin
         pow_h[k+1] = (pow_h[k] * xh_w + 128'sd8192) >>> 14;
         pow_l[k+1] = (pow_l[k] * xl_w + 128'sd8192) >>> 14;
      end
      // term sums, reciprocal is round(2^32 / (i + 1))
      val_sum  = '0;
      area_sum = '0;
      for (int i = 0; i < MAX_TERMS && i < NUM_COEF; i++) begin
         a_w      = coef_copy[i];
         recip    = ((128'sd1 <<< 33) + wide_type'(i + 1)) / wide_type'(2 * (i + 1));
         val_sum  = val_sum + mul_q32(a_w, pow_h[i]);
         area_sum = area_sum + mul_q32(recip, mul_q32(a_w, pow_h[i+1] - pow_l[i+1]));
      end
      // clamp to q24.24
      r.overflow = 1'b0;
      if (val_sum > SUM_MAX) begin
         val_sum    = SUM_MAX;
         r.overflow = 1'b1;
      end else if (val_sum < SUM_MIN) begin
         val_sum    = SUM_MIN;
         r.overflow = 1'b1;
      end
      if (area_sum > SUM_MAX) begin
         area_sum   = SUM_MAX;
         r.overflow = 1'b1;
      end else if (area_sum < SUM_MIN) begin
         area_sum   = SUM_MIN;
         r.overflow = 1'b1;
      end
      r.value_at_high = val_sum[pol_pkg::OUT_W-1:0];
      r.area          = area_sum[pol_pkg::OUT_W-1:0];
      return r;
   endfunction

   function automatic void add_row(input dir_set_type s, input lim_type xl, input lim_type xh,
                                   input bit known, input q48_type v, input q48_type a);
      dir_row_type row;
      row.set_id              = s;
      row.xl                  = xl;
      row.xh                  = xh;
      row.known               = known;
      row.fixed.value_at_high = v;
      row.fixed.area          = a;
      row.fixed.overflow      = 1'b0;
      dir_tab.push_back(row);
   endfunction

   // limit biased toward the range ends, zero and 1.0
   function automatic lim_type pick_limit();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'sh4000;
         default: return lim_type'($urandom);
      endcase
   endfunction

   function automatic coef_type rand_coef(input coef_mode_type mode, input int idx,
                                          input int degree);
      coef_type c;
      c = coef_type'($urandom);
      case (mode)
         CM_EXTREME: begin
            case ($urandom_range(0, 2))
               0: c = COEF_MAX;
               1: c = COEF_MIN;
               default: c = '0;
            endcase
         end
         CM_DEGREE: begin
            if (idx > degree) c = '0;
         end
         CM_SMALL: begin
            c = coef_type'(int'($urandom_range(0, 32'h0200_0000)) - int'(COEF_ONE));
            if (idx > degree) c = '0;
         end
         default: ;
      endcase
      return c;
   endfunction

   // offer one item and hold it until accepted
   task automatic offer_item(input lim_type xl, input lim_type xh, input bit known,
                             input va_result_type fixed);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_x_low  <= xl;
      req_x_high <= xh;
      row_known  <= known;
      row_result <= fixed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop offering and wait for every pending result
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (value_area_q.size() != 0) @(posedge clock);
   endtask

   task automatic load_coefs(input coef_set_type c);
      for (int i = 0; i < NUM_COEF; i++) begin
         csr_we    <= 1'b1;
         csr_index <= pol_pkg::pol_idx_type'(i);
         csr_wdata <= c[i];
         @(posedge clock);
         coef_copy[i] = c[i];
      end
      csr_we <= 1'b0;
   endtask

   // stimulus
   initial begin
      dir_set_type   cur_set;
      coef_set_type  phase_set;
      coef_mode_type mode;
      int            degree;
      lim_type       xl;
      lim_type       xh;
      for (int i = 0; i < NUM_COEF; i++) begin
         coef_copy[i]             = '0;
         dir_sets[SET_ZERO][i]    = '0;
         dir_sets[SET_UNITY][i]   = (i == 0) ? COEF_ONE : '0;
         dir_sets[SET_ALL_MAX][i] = COEF_MAX;
         dir_sets[SET_ALL_MIN][i] = COEF_MIN;
         dir_sets[SET_X7][i]      = (i == NUM_COEF - 1) ? COEF_ONE : '0;
      end

      // zero polynomial after reset
      add_row(SET_ZERO, 16'sh8000, 16'sh7FFF, 1, 0, 0);
      add_row(SET_ZERO, 16'sh7FFF, 16'sh8000, 1, 0, 0);
      add_row(SET_ZERO, 16'sh0000, 16'sh0000, 1, 0, 0);
      add_row(SET_ZERO, 16'sh4000, 16'shC000, 1, 0, 0);
      // constant 1.0: area is the interval width, negated when reversed
      add_row(SET_UNITY, 16'sh0000, 16'sh4000, 1, VAL_ONE, 48'sd16777216);
      add_row(SET_UNITY, 16'sh8000, 16'sh7FFF, 1, VAL_ONE, 48'sd67107840);
      add_row(SET_UNITY, 16'sh7FFF, 16'sh8000, 1, VAL_ONE, -48'sd67107840);
      add_row(SET_UNITY, 16'shC000, 16'sh4000, 1, VAL_ONE, 48'sd33554432);
      add_row(SET_UNITY, 16'sh0064, 16'sh0064, 1, VAL_ONE, 48'sd0);
      add_row(SET_UNITY, 16'sh8000, 16'sh8000, 1, VAL_ONE, 48'sd0);
      // extreme coefficients at extreme limits
      add_row(SET_ALL_MAX, 16'sh8000, 16'sh7FFF, 0, 0, 0);
      add_row(SET_ALL_MAX, 16'sh7FFF, 16'sh8000, 0, 0, 0);
      add_row(SET_ALL_MAX, 16'sh0000, 16'sh0000, 0, 0, 0);
      add_row(SET_ALL_MAX, 16'sh8000, 16'sh8000, 0, 0, 0);
      add_row(SET_ALL_MAX, 16'sh7FFF, 16'sh7FFF, 0, 0, 0);
      add_row(SET_ALL_MIN, 16'sh8000, 16'sh7FFF, 0, 0, 0);
      add_row(SET_ALL_MIN, 16'sh7FFF, 16'sh8000, 0, 0, 0);
      add_row(SET_ALL_MIN, 16'sh0000, 16'sh0000, 0, 0, 0);
      add_row(SET_ALL_MIN, 16'sh8000, 16'sh8000, 0, 0, 0);
      add_row(SET_ALL_MIN, 16'sh7FFF, 16'sh7FFF, 0, 0, 0);
      // highest term alone
      add_row(SET_X7, 16'sh8000, 16'sh7FFF, 0, 0, 0);
      add_row(SET_X7, 16'sh4000, 16'shC000, 0, 0, 0);
      add_row(SET_X7, 16'sh0000, 16'sh7FFF, 0, 0, 0);
      add_row(SET_X7, 16'shFFFF, 16'sh0001, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      cur_set = SET_ZERO;
      foreach (dir_tab[r]) begin
         if (dir_tab[r].set_id != cur_set) begin
            drain();
            load_coefs(dir_sets[dir_tab[r].set_id]);
            cur_set = dir_tab[r].set_id;
         end
         offer_item(dir_tab[r].xl, dir_tab[r].xh, dir_tab[r].known, dir_tab[r].fixed);
      end

      // random phases, each with its own coefficient set
      for (int p = 0; p < NUM_PHASES; p++) begin
         mode   = coef_mode_type'(p % 4);
         degree = $urandom_range(0, NUM_COEF - 1);
         for (int i = 0; i < NUM_COEF; i++) phase_set[i] = rand_coef(mode, i, degree);
         drain();
         load_coefs(phase_set);
         idle_on = !(p == 6 || p == 7);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 3 && n == 8) pressure_go = 1'b1;
            xl = pick_limit();
            xh = ($urandom_range(0, 9) == 0) ? xl : pick_limit();
            offer_item(xl, xh, 1'b0, '0);
         end
      end

      drain();
      repeat (LATENCY + 12) @(posedge clock);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // receiver: random stalls, one long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (pressure_go && !pressure_done) begin
         pressure_done = 1'b1;
         hold_left     = HOLD_CYCLES;
         rsp_ready     <= 1'b0;
      end else begin
         rsp_ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
      end
   end

   // check each result against the oldest expectation, then record new items
   always @(posedge clock) begin
      va_result_type got;
      va_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.value_at_high = rsp_value_at_high;
            got.area          = rsp_area;
            got.overflow      = rsp_overflow;
            if (value_area_q.size() == 0) begin
               err_count = err_count + 1;
               if (err_count <= 10)
                  $display("unexpected result: value %0d area %0d ovf %0b",
                           got.value_at_high, got.area, got.overflow);
            end else begin
               want = value_area_q.pop_front();
               if (got.value_at_high !== want.value_at_high || got.area !== want.area ||
                   got.overflow !== want.overflow) begin
                  err_count = err_count + 1;
                  if (err_count <= 10) begin
                     $display("result %0d mismatch: expected value %0d area %0d ovf %0b",
                              result_no, want.value_at_high, want.area, want.overflow);
                     $display("   got value %0d area %0d ovf %0b",
                              got.value_at_high, got.area, got.overflow);
                  end
               end
            end
            result_no = result_no + 1;
         end
         if (req_valid && req_ready)
            value_area_q.push_back(row_known ? row_result
                                             : poly_value_and_area(req_x_low, req_x_high));
      end
   end

   // run limit
   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
